### rtl/core/window_weighted_square_count_sum_macros.svh
// Assertion macros for the window weighted square count sum block.
// Self-contained; no dependencies. Bodies vanish when SYNTHESIS is defined.
`ifndef WINDOW_WEIGHTED_SQUARE_COUNT_SUM_MACROS_SVH
`define WINDOW_WEIGHTED_SQUARE_COUNT_SUM_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising clock edge out of reset
`define WWSC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wwsc: same-cycle check failed");
// next-cycle implication
`define WWSC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wwsc: next-cycle check failed");
`else
`define WWSC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define WWSC_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/wwsc_pkg.sv
// Shared sizes, codes and widths for the window weighted square count sum block.
// No dependencies; used by the channel interfaces and the top level.
package wwsc_pkg;

  localparam int MaxElements = 4096;
  localparam int ValueBits   = 12;

  localparam int HistDepth = 1 << ValueBits;
  localparam int AddrW     = $clog2(MaxElements);
  localparam int WinW      = AddrW + 1;
  localparam int LenW      = 13;
  localparam int FieldW    = 12;
  localparam int CntW      = WinW;
  localparam int ProdW     = CntW + 1 + ValueBits;
  localparam int SumW      = 37;
  localparam int ClrDepth  = (MaxElements > HistDepth) ? MaxElements : HistDepth;
  localparam int ClrW      = $clog2(ClrDepth);

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

endpackage

### rtl/core/wwsc_in_if.sv
// Input channel: one load or query beat with valid/ready handshake.
// Depends on wwsc_pkg for field widths.
interface wwsc_in_if import wwsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [FieldW-1:0] index;
  logic [FieldW-1:0] value;
  logic [FieldW-1:0] range_low;
  logic [FieldW-1:0] range_high;

  modport source (output valid, operation, index, value, range_low, range_high,
                  input ready);
  modport sink   (input valid, operation, index, value, range_low, range_high,
                  output ready);
endinterface

### rtl/core/wwsc_out_if.sv
// Output channel: one result beat (weighted sum and status) with valid/ready.
// Depends on wwsc_pkg for field widths.
interface wwsc_out_if import wwsc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SumW-1:0] weighted_sum;
  logic            status;

  modport source (output valid, weighted_sum, status, input ready);
  modport sink   (input valid, weighted_sum, status, output ready);
endinterface

### rtl/core/window_weighted_square_count_sum.sv
// Channel   | Dir | Handshake        | Payload
// in_i      | in  | valid/ready      | operation, index, value, range_low, range_high
// out_o     | out | valid/ready      | weighted_sum, status
// cfg       | in  | cfg_we_i         | cfg_wdata_i -> array_length
//
// After reset a clearing pass zeroes both memories; no input is taken until it ends.
// Each query element step (enter or leave) is an edge planning state, store read,
// histogram read, multiply and histogram write-back. A load inside the window
// first removes the old value, then enters the new one. Bad bounds go straight
// to the result. A stalled output holds the finished beat while the next input
// beat is taken; the block then waits to present its result.
`include "window_weighted_square_count_sum_macros.svh"

module window_weighted_square_count_sum import wwsc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  wwsc_in_if.sink         in_i,
  wwsc_out_if.source      out_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PLAN  = 4'd2;
  localparam logic [3:0] S_RD_ST = 4'd3;
  localparam logic [3:0] S_RD_HI = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_WB    = 4'd6;
  localparam logic [3:0] S_LDWR  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // memories
  logic [ValueBits-1:0] store_mem [MaxElements];
  logic [CntW-1:0]      hist_mem  [HistDepth];

  // control state
  logic [3:0]      state_q, state_d;
  logic [ClrW-1:0] clr_q, clr_d;
  logic [LenW-1:0] len_q, len_d;
  logic [WinW-1:0] win_start_q, win_start_d;
  logic [WinW-1:0] win_end_q, win_end_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic            out_valid_q, out_valid_d;
  logic            ld_pend_q, ld_pend_d;

  // payload registers
  logic                 op_q, op_d;
  logic [AddrW-1:0]     idx_q, idx_d;
  logic [ValueBits-1:0] ldval_q, ldval_d;
  logic [AddrW-1:0]     lo_q, lo_d;
  logic [AddrW-1:0]     hi_q, hi_d;
  logic [AddrW-1:0]     pos_q, pos_d;
  logic                 enter_q, enter_d;
  logic                 from_load_q, from_load_d;
  logic                 err_q, err_d;
  logic [ValueBits-1:0] hv_q, hv_d;
  logic [ProdW-1:0]     prod_q, prod_d;
  logic [CntW-1:0]      cnt_new_q, cnt_new_d;
  logic                 skip_q, skip_d;
  logic [SumW-1:0]      out_sum_q, out_sum_d;
  logic                 out_status_q, out_status_d;

  // memory read data
  logic [ValueBits-1:0] st_rd_q;
  logic [CntW-1:0]      hist_rd_q;

  // memory ports
  logic                 st_we;
  logic [AddrW-1:0]     st_waddr;
  logic [ValueBits-1:0] st_wdata;
  logic                 hist_we;
  logic [ValueBits-1:0] hist_waddr;
  logic [CntW-1:0]      hist_wdata;
  logic [ValueBits-1:0] hist_raddr;

  // decode helpers
  logic            in_acc;
  logic            in_bad;
  logic [LenW-1:0] len_eff;
  logic [WinW-1:0] in_idx_w;
  logic            in_window;
  logic [WinW-1:0] lo_w;
  logic [WinW-1:0] hi1_w;
  logic [CntW-1:0] fac_base;
  logic            out_free;

  assign len_eff = (len_q > LenW'(MaxElements)) ? LenW'(MaxElements) : len_q;
  assign in_acc  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    if (in_i.operation == OpLoad) begin
      in_bad = (LenW'(in_i.index) >= len_eff);
    end else begin
      in_bad = (in_i.range_low > in_i.range_high) || (LenW'(in_i.range_high) >= len_eff);
    end
  end

  assign in_idx_w  = WinW'(in_i.index[AddrW-1:0]);
  assign in_window = (in_idx_w >= win_start_q) && (in_idx_w < win_end_q);
  assign lo_w      = WinW'(lo_q);
  assign hi1_w     = WinW'(hi_q) + WinW'(1);
  assign fac_base  = enter_q ? hist_rd_q : (hist_rd_q - CntW'(1));
  assign out_free  = !out_valid_q || out_o.ready;

  assign hist_raddr = from_load_q ? ldval_q : st_rd_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    len_d        = cfg_we_i ? cfg_wdata_i : len_q;
    win_start_d  = win_start_q;
    win_end_d    = win_end_q;
    sum_d        = sum_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    ld_pend_d    = ld_pend_q;
    op_d         = op_q;
    idx_d        = idx_q;
    ldval_d      = ldval_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    pos_d        = pos_q;
    enter_d      = enter_q;
    from_load_d  = from_load_q;
    err_d        = err_q;
    hv_d         = hv_q;
    prod_d       = prod_q;
    cnt_new_d    = cnt_new_q;
    skip_d       = skip_q;
    out_sum_d    = out_sum_q;
    out_status_d = out_status_q;
    st_we        = 1'b0;
    st_waddr     = idx_q;
    st_wdata     = ldval_q;
    hist_we      = 1'b0;
    hist_waddr   = hv_q;
    hist_wdata   = cnt_new_q;

    unique case (state_q)
      S_CLEAR: begin
        st_we      = ({1'b0, clr_q} < (ClrW+1)'(MaxElements));
        st_waddr   = clr_q[AddrW-1:0];
        st_wdata   = '0;
        hist_we    = ({1'b0, clr_q} < (ClrW+1)'(HistDepth));
        hist_waddr = clr_q[ValueBits-1:0];
        hist_wdata = '0;
        clr_d      = clr_q + ClrW'(1);
        if (clr_q == ClrW'(ClrDepth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_d        = in_i.operation;
          idx_d       = in_i.index[AddrW-1:0];
          ldval_d     = in_i.value[ValueBits-1:0];
          lo_d        = in_i.range_low[AddrW-1:0];
          hi_d        = in_i.range_high[AddrW-1:0];
          err_d       = in_bad;
          from_load_d = 1'b0;
          if (in_bad) begin
            state_d = S_DONE;
          end else if (in_i.operation == OpQuery) begin
            state_d = S_PLAN;
          end else if (in_window) begin
            // old value leaves first, then the new one enters
            pos_d     = in_i.index[AddrW-1:0];
            enter_d   = 1'b0;
            ld_pend_d = 1'b1;
            state_d   = S_RD_ST;
          end else begin
            state_d = S_LDWR;
          end
        end
      end
      S_PLAN: begin
        from_load_d = 1'b0;
        state_d     = S_RD_ST;
        // grow both edges before shrinking either
        if (win_end_q < hi1_w) begin
          pos_d     = win_end_q[AddrW-1:0];
          enter_d   = 1'b1;
          win_end_d = win_end_q + WinW'(1);
        end else if (win_start_q > lo_w) begin
          pos_d       = AddrW'(win_start_q - WinW'(1));
          enter_d     = 1'b1;
          win_start_d = win_start_q - WinW'(1);
        end else if (win_end_q > hi1_w) begin
          pos_d     = AddrW'(win_end_q - WinW'(1));
          enter_d   = 1'b0;
          win_end_d = win_end_q - WinW'(1);
        end else if (win_start_q < lo_w) begin
          pos_d       = win_start_q[AddrW-1:0];
          enter_d     = 1'b0;
          win_start_d = win_start_q + WinW'(1);
        end else begin
          state_d = S_DONE;
        end
      end
      S_RD_ST: begin
        state_d = S_RD_HI;
      end
      S_RD_HI: begin
        hv_d    = hist_raddr;
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d    = ProdW'({fac_base, 1'b1}) * ProdW'(hv_q);
        cnt_new_d = enter_q ? (hist_rd_q + CntW'(1)) : (hist_rd_q - CntW'(1));
        skip_d    = !enter_q && (hist_rd_q == '0);
        state_d   = S_WB;
      end
      S_WB: begin
        if (!skip_q) begin
          hist_we = 1'b1;
          if (enter_q) begin
            sum_d = sum_q + SumW'(prod_q);
          end else begin
            sum_d = sum_q - SumW'(prod_q);
          end
        end
        if (ld_pend_q) begin
          ld_pend_d   = 1'b0;
          enter_d     = 1'b1;
          from_load_d = 1'b1;
          state_d     = S_RD_HI;
        end else if (op_q == OpLoad) begin
          state_d = S_LDWR;
        end else begin
          state_d = S_PLAN;
        end
      end
      S_LDWR: begin
        st_we   = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_sum_d    = err_q ? '0 : sum_q;
          out_status_d = err_q ? StatusErr : StatusOk;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    st_rd_q <= store_mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rd_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      len_q       <= LenW'(MaxElements);
      win_start_q <= '0;
      win_end_q   <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      ld_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      len_q       <= len_d;
      win_start_q <= win_start_d;
      win_end_q   <= win_end_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      ld_pend_q   <= ld_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    idx_q        <= idx_d;
    ldval_q      <= ldval_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    pos_q        <= pos_d;
    enter_q      <= enter_d;
    from_load_q  <= from_load_d;
    err_q        <= err_d;
    hv_q         <= hv_d;
    prod_q       <= prod_d;
    cnt_new_q    <= cnt_new_d;
    skip_q       <= skip_d;
    out_sum_q    <= out_sum_d;
    out_status_q <= out_status_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.weighted_sum = out_sum_q;
  assign out_o.status       = out_status_q;

  `WWSC_ASSERT_IMP(a_win_order, clk_i, rst_ni, 1'b1, win_start_q <= win_end_q)
  `WWSC_ASSERT_IMP(a_win_bound, clk_i, rst_ni, 1'b1, win_end_q <= WinW'(MaxElements))
  `WWSC_ASSERT_NXT(a_bad_to_done, clk_i, rst_ni, in_acc && in_bad, state_q == S_DONE)
  `WWSC_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_o.valid && (out_o.status == StatusErr), out_o.weighted_sum == '0)

endmodule

### bench/tb_window_weighted_square_count_sum.sv
// Self-checking bench for window_weighted_square_count_sum: loads and range queries
// checked against an in-bench model of the window, histogram and weighted sum.
// Depends on wwsc_pkg, wwsc_in_if and wwsc_out_if from the RTL.
module tb_window_weighted_square_count_sum;
  import wwsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ResetCycles    = 11;
  localparam int SettleCycles   = 40;
  localparam int WatchdogLimit  = 200000;
  localparam int PressureCycles = 400;
  localparam int PhaseItems     = 67;

  typedef struct {
    logic              op;
    logic [FieldW-1:0] index;
    logic [FieldW-1:0] value;
    logic [FieldW-1:0] lo;
    logic [FieldW-1:0] hi;
  } beat_t;

  typedef struct {
    logic [SumW-1:0] sum;
    logic            status;
  } result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  logic [LenW-1:0] cfg_wdata;

  wwsc_in_if  in_if ();
  wwsc_out_if out_if ();

  window_weighted_square_count_sum dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Model state
  logic [ValueBits-1:0] element_mirror [MaxElements];
  logic [CntW-1:0]      value_count    [HistDepth];
  logic [WinW-1:0]      win_lo;
  logic [WinW-1:0]      win_hi;
  logic [SumW-1:0]      weighted_acc;
  logic [LenW-1:0]      length_mirror;

  beat_t   item_backlog[$];
  result_t sum_expected_q[$];
  beat_t   offered;
  result_t got;
  result_t want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pressure_at   = -1;
  int results_seen  = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int failures      = 0;
  int band_base     = 0;

  function automatic void enter_value(logic [ValueBits-1:0] v);
    logic [SumW-1:0] c;
    c = SumW'(value_count[v]);
    weighted_acc = weighted_acc + (2 * c + 1) * SumW'(v);
    value_count[v] = value_count[v] + 1'b1;
  endfunction

  function automatic void leave_value(logic [ValueBits-1:0] v);
    logic [SumW-1:0] c;
    c = SumW'(value_count[v]);
    if (c != 0) begin
      weighted_acc = weighted_acc - (2 * c - 1) * SumW'(v);
      value_count[v] = value_count[v] - 1'b1;
    end
  endfunction

  function automatic result_t compute_window_sum(beat_t b);
    logic [LenW-1:0] len;
    logic [WinW-1:0] top;
    result_t r;
    len = (length_mirror > LenW'(MaxElements)) ? LenW'(MaxElements) : length_mirror;
    top = WinW'(b.hi) + 1'b1;
    r.sum = '0;
    r.status = StatusErr;
    if (b.op == OpLoad) begin
      if (LenW'(b.index) < len) begin
        if (WinW'(b.index) >= win_lo && WinW'(b.index) < win_hi) begin
          leave_value(element_mirror[b.index]);
          enter_value(b.value);
        end
        element_mirror[b.index] = b.value;
        r.sum = weighted_acc;
        r.status = StatusOk;
      end
    end else if (b.lo <= b.hi && LenW'(b.hi) < len) begin
      // grow both edges before shrinking so no count goes negative
      while (win_hi < top) begin
        enter_value(element_mirror[win_hi[AddrW-1:0]]);
        win_hi = win_hi + 1'b1;
      end
      while (win_lo > WinW'(b.lo)) begin
        win_lo = win_lo - 1'b1;
        enter_value(element_mirror[win_lo[AddrW-1:0]]);
      end
      while (win_hi > top) begin
        win_hi = win_hi - 1'b1;
        leave_value(element_mirror[win_hi[AddrW-1:0]]);
      end
      while (win_lo < WinW'(b.lo)) begin
        leave_value(element_mirror[win_lo[AddrW-1:0]]);
        win_lo = win_lo + 1'b1;
      end
      r.sum = weighted_acc;
      r.status = StatusOk;
    end
    return r;
  endfunction

  function automatic void queue_load(int idx, int val);
    beat_t b;
    b.op = OpLoad;
    b.index = FieldW'(idx);
    b.value = FieldW'(val);
    b.lo = FieldW'($urandom);
    b.hi = FieldW'($urandom);
    item_backlog.push_back(b);
  endfunction

  function automatic void queue_query(int lo, int hi);
    beat_t b;
    b.op = OpQuery;
    b.index = FieldW'($urandom);
    b.value = FieldW'($urandom);
    b.lo = FieldW'(lo);
    b.hi = FieldW'(hi);
    item_backlog.push_back(b);
  endfunction

  // span of 4096 keeps queries in a slowly drifting band so walks stay short
  function automatic void queue_random(int count, int span);
    int idx;
    int val;
    int lo;
    int hi;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if ($urandom_range(1) == 0) begin
        if (pick < 10) idx = $urandom_range(4095);
        else if (span < MaxElements) idx = $urandom_range(span - 1);
        else idx = band_base + $urandom_range(63);
        pick = $urandom_range(99);
        if (pick < 50) val = $urandom_range(3);
        else if (pick < 70) val = 4094 + $urandom_range(1);
        else val = $urandom_range(4095);
        queue_load(idx, val);
      end else if (pick < 5) begin
        hi = $urandom_range(4094);
        queue_query($urandom_range(4095, hi + 1), hi);
      end else if (pick < 10) begin
        queue_query($urandom_range(4095), $urandom_range(4095));
      end else if (span < MaxElements) begin
        lo = $urandom_range(span - 1);
        queue_query(lo, $urandom_range(span - 1, lo));
      end else begin
        band_base = band_base + $urandom_range(64) - 32;
        if (band_base < 0) band_base = 0;
        if (band_base > 4095 - 64) band_base = 4095 - 64;
        lo = band_base + $urandom_range(31);
        hi = lo + $urandom_range(31);
        queue_query(lo, hi);
      end
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (item_backlog.size() != 0 || in_if.valid || sum_expected_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_length(int len);
    wait_idle();
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= LenW'(len);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    length_mirror = LenW'(len);
    @(negedge clk_i);
  endtask

  // Driver: present backlog beats, hold each until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.operation  <= OpLoad;
      in_if.index      <= '0;
      in_if.value      <= '0;
      in_if.range_low  <= '0;
      in_if.range_high <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        sum_expected_q.push_back(compute_window_sum(offered));
      end
      if (!in_if.valid || in_if.ready) begin
        if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = item_backlog.pop_front();
          in_if.valid      <= 1'b1;
          in_if.operation  <= offered.op;
          in_if.index      <= offered.index;
          in_if.value      <= offered.value;
          in_if.range_low  <= offered.lo;
          in_if.range_high <= offered.hi;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.sum = out_if.weighted_sum;
        got.status = out_if.status;
        if (sum_expected_q.size() == 0) begin
          failures++;
          $display("%0t: unexpected result beat sum %0d status %0d",
                   $time, got.sum, got.status);
        end else begin
          want = sum_expected_q.pop_front();
          if (got.sum !== want.sum) begin
            failures++;
            $display("%0t: weighted_sum expected %0d got %0d", $time, want.sum, got.sum);
          end
          if (got.status !== want.status) begin
            failures++;
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          end
        end
        results_seen++;
        if (results_seen == pressure_at) hold_left = PressureCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < MaxElements; i++) element_mirror[i] = '0;
    for (int i = 0; i < HistDepth; i++) value_count[i] = '0;
    win_lo = '0;
    win_hi = '0;
    weighted_acc = '0;
    length_mirror = LenW'(4096);
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Full length: empty window, full walk out and back, loads in and out of window
    queue_query(0, 0);
    queue_load(0, 4095);
    queue_load(4095, 4095);
    queue_query(0, 4095);
    queue_load(5, 4095);
    queue_load(5, 0);
    queue_query(4095, 4095);
    queue_query(3, 2);
    queue_query(10, 20);

    // Zero length rejects everything
    set_length(0);
    queue_load(0, 1);
    queue_query(0, 0);

    // Oversized length clamps to the store size
    set_length(8191);
    queue_query(4095, 4095);
    queue_load(4095, 7);

    set_length(1);
    queue_load(1, 3);
    queue_query(0, 0);
    queue_query(0, 1);
    queue_load(0, 9);

    // Shrink the length under a wide window, then walk past the stale tail
    set_length(64);
    queue_load(40, 5);
    queue_load(41, 5);
    queue_query(0, 63);
    set_length(8);
    queue_query(2, 5);
    queue_load(40, 1);

    set_length(64);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pressure_at = results_seen + 10;
    queue_random(PhaseItems, 64);

    set_length(16);
    send_idle_pct = 56;
    recv_idle_pct = 0;
    queue_random(PhaseItems, 16);

    set_length(256);
    send_idle_pct = 0;
    recv_idle_pct = 56;
    queue_random(PhaseItems, 256);

    set_length(4096);
    send_idle_pct = 10;
    recv_idle_pct = 10;
    band_base = $urandom_range(4095 - 64);
    queue_random(PhaseItems, 4096);

    wait_idle();
    if (failures == 0 && sum_expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
